@@ rtl/vpd_pkg.sv @@
// Shared types, constants and a helper function of the volume plane decimator.
package vpd_pkg;

  // Axis geometry: sizes up to MAX_AXIS, indexes below it.
  localparam int MAX_AXIS   = 4096;
  localparam int AXIS_W     = $clog2(MAX_AXIS);
  localparam int SIZE_W     = AXIS_W + 1;
  // Accumulators reach MAX_AXIS squared.
  localparam int ACC_W      = 2 * AXIS_W + 1;
  localparam int VALUE_BITS = 32;
  localparam int NUM_AXES   = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int NUM_REGS   = 6;

  // Register values after reset.
  localparam int RESET_SIZE = 256;
  localparam int RESET_DROP = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_DROP_X = 3'd3,
    REG_DROP_Y = 3'd4,
    REG_DROP_Z = 3'd5
  } cfg_reg_t;

  // Effective settings of one axis.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [AXIS_W-1:0] drop;
  } axis_cfg_t;

  // Per-axis status for the current index.
  typedef struct packed {
    logic discarded;
    logic last;
  } axis_stat_t;

  // Clamp raw register values into the legal range of one axis.
  function automatic axis_cfg_t eff_axis(input logic [SIZE_W-1:0] size_raw,
                                         input logic [AXIS_W-1:0] drop_raw);
    axis_cfg_t res;
    if (size_raw == '0) begin
      res.size = SIZE_W'(1);
    end else if (size_raw > SIZE_W'(MAX_AXIS)) begin
      res.size = SIZE_W'(MAX_AXIS);
    end else begin
      res.size = size_raw;
    end
    if ({1'b0, drop_raw} >= res.size) begin
      res.drop = AXIS_W'(res.size - SIZE_W'(1));
    end else begin
      res.drop = drop_raw;
    end
    return res;
  endfunction

endpackage

@@ rtl/vpd_cfg.sv @@
// Configuration register file with clamping of sizes and drop counts.
module vpd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output vpd_pkg::axis_cfg_t             axis_cfg [vpd_pkg::NUM_AXES],
  output logic                           restart
);
  import vpd_pkg::*;

  logic [SIZE_W-1:0] size_reg      [NUM_AXES];
  logic [AXIS_W-1:0] drop_reg      [NUM_AXES];
  logic [SIZE_W-1:0] size_reg_next [NUM_AXES];
  logic [AXIS_W-1:0] drop_reg_next [NUM_AXES];
  logic              hit;

  // Decode the write; an index past the register list changes nothing.
  always_comb begin
    size_reg_next = size_reg;
    drop_reg_next = drop_reg;
    hit           = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: begin size_reg_next[0] = SIZE_W'(cfg_data); hit = 1'b1; end
        REG_SIZE_Y: begin size_reg_next[1] = SIZE_W'(cfg_data); hit = 1'b1; end
        REG_SIZE_Z: begin size_reg_next[2] = SIZE_W'(cfg_data); hit = 1'b1; end
        REG_DROP_X: begin drop_reg_next[0] = AXIS_W'(cfg_data); hit = 1'b1; end
        REG_DROP_Y: begin drop_reg_next[1] = AXIS_W'(cfg_data); hit = 1'b1; end
        REG_DROP_Z: begin drop_reg_next[2] = AXIS_W'(cfg_data); hit = 1'b1; end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        size_reg[i] <= SIZE_W'(RESET_SIZE);
        drop_reg[i] <= AXIS_W'(RESET_DROP);
      end
    end else begin
      size_reg <= size_reg_next;
      drop_reg <= drop_reg_next;
    end
  end

  // The axes see the settings being written so a restart loads the new values.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      axis_cfg[i] = eff_axis(size_reg_next[i], drop_reg_next[i]);
    end
  end

  assign restart = hit;

endmodule

@@ rtl/vpd_axis.sv @@
// Position tracker of one axis with exact integer discard test.
module vpd_axis (
  input  logic                       clk,
  input  logic                       rst,
  input  vpd_pkg::axis_cfg_t         cfg,
  input  logic                       restart,
  input  logic                       step,
  output vpd_pkg::axis_stat_t        stat,
  output logic [vpd_pkg::AXIS_W-1:0] kept_idx
);
  import vpd_pkg::*;

  logic [AXIS_W-1:0] pos;
  logic [AXIS_W-1:0] kept;
  logic [AXIS_W-1:0] cnt;
  logic [ACC_W-1:0]  discard_acc;
  logic [ACC_W-1:0]  bound_acc;
  logic [ACC_W-1:0]  drop_inc;

  // Index is dropped while drops remain and N*(c+1) < (D+1)*(pos+1).
  assign stat.discarded = (cnt < cfg.drop) && (discard_acc < bound_acc);
  assign stat.last      = (SIZE_W'(pos) + SIZE_W'(1)) >= cfg.size;
  assign kept_idx       = kept;
  assign drop_inc       = ACC_W'(cfg.drop) + ACC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      kept        <= '0;
      cnt         <= '0;
      discard_acc <= ACC_W'(RESET_SIZE);
      bound_acc   <= ACC_W'(RESET_DROP + 1);
    end else if (restart || (step && stat.last)) begin
      // New scan, or wrap at the end of the axis.
      pos         <= '0;
      kept        <= '0;
      cnt         <= '0;
      discard_acc <= ACC_W'(cfg.size);
      bound_acc   <= drop_inc;
    end else if (step) begin
      if (stat.discarded) begin
        cnt         <= cnt + AXIS_W'(1);
        discard_acc <= discard_acc + ACC_W'(cfg.size);
      end else begin
        kept <= kept + AXIS_W'(1);
      end
      pos       <= pos + AXIS_W'(1);
      bound_acc <= bound_acc + drop_inc;
    end
  end

endmodule

@@ rtl/volume_plane_decimator_top.sv @@
// Top level of the volume plane decimator.
//
// Voxels enter on the input channel (in_valid, in_stall, voxel_value) in
// raster order, x fastest, then y, then z. Each beat is tested against the
// discard pattern of its x column, y row and z plane; a kept voxel leaves
// on the output channel (out_valid, out_stall) with its coarse coordinates,
// a dropped voxel produces no beat.
// A kept voxel accepted at one edge is shown in the output register from the
// next cycle on. One voxel is taken every cycle while the input is not stalled;
// the rate is set by the per-axis counters and accumulators.
// When the receiver stalls, the output register holds its beat and the
// input is stalled only while a beat waits there; dropped voxels are still
// consumed whenever the output register is empty or being drained.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; any write to a listed register restarts the scan at voxel
// (0,0,0). Reset loads sizes of 256, drop counts of 0, empties the output
// register and restarts the scan. The scan wraps after the last voxel.
module volume_plane_decimator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [vpd_pkg::VALUE_BITS-1:0]   voxel_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [vpd_pkg::VALUE_BITS-1:0]   kept_value,
  output logic [vpd_pkg::AXIS_W-1:0]       coarse_x,
  output logic [vpd_pkg::AXIS_W-1:0]       coarse_y,
  output logic [vpd_pkg::AXIS_W-1:0]       coarse_z,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vpd_pkg::*;

  axis_cfg_t         axis_cfg [NUM_AXES];
  axis_stat_t        stat     [NUM_AXES];
  logic [AXIS_W-1:0] kept_idx [NUM_AXES];
  logic [NUM_AXES-1:0] step;
  logic              restart;
  logic              accept;
  logic              keep;

  assign cfg_ready = 1'b1;

  vpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .axis_cfg  (axis_cfg),
    .restart   (restart)
  );

  // Stall only while a finished beat waits in the output register.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // An outer axis moves only when every inner axis wraps.
  assign step[0] = accept;
  assign step[1] = step[0] && stat[0].last;
  assign step[2] = step[1] && stat[1].last;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    vpd_axis u_axis (
      .clk      (clk),
      .rst      (rst),
      .cfg      (axis_cfg[a]),
      .restart  (restart),
      .step     (step[a]),
      .stat     (stat[a]),
      .kept_idx (kept_idx[a])
    );
  end

  assign keep = !stat[0].discarded && !stat[1].discarded && !stat[2].discarded;

  // Output register: valid bit under reset, payload loaded when a kept voxel is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= keep;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      kept_value <= voxel_value;
      coarse_x   <= kept_idx[0];
      coarse_y   <= kept_idx[1];
      coarse_z   <= kept_idx[2];
    end
  end

endmodule

@@ rtl/vpd_checker.sv @@
// Port-level checks of the volume plane decimator and their binding.
module vpd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [vpd_pkg::VALUE_BITS-1:0]   kept_value,
  input logic [vpd_pkg::AXIS_W-1:0]       coarse_x,
  input logic [vpd_pkg::AXIS_W-1:0]       coarse_y,
  input logic [vpd_pkg::AXIS_W-1:0]       coarse_z,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [vpd_pkg::CFG_IDX_W-1:0]    cfg_index
);
  import vpd_pkg::*;

  // A stalled output beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(kept_value) && $stable(coarse_x) &&
                               $stable(coarse_y) && $stable(coarse_z))
    else $error("output payload changed while stalled");

  // The input is held back only by a waiting output beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting output beat");

  // The first voxel after a register write is the coarse origin and is kept.
  a_restart_origin: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS)))
      ##1 (in_valid && !in_stall)
    |=> out_valid && (coarse_x == '0) && (coarse_y == '0) && (coarse_z == '0))
    else $error("scan did not restart at the origin");

endmodule

bind volume_plane_decimator_top vpd_checker u_vpd_checker (.*);
